[sv/bdu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdu_pkg
// shared types, constants and tables for the bcd date/time to epoch converter
// ----------------------------------------------------------------------------
package bdu_pkg;

  localparam int unsigned FieldW  = 8;    // one two-digit bcd field
  localparam int unsigned BinW    = 7;    // binary value of two bcd digits
  localparam int unsigned DaysW   = 16;   // day count since 1970
  localparam int unsigned HmsW    = 19;   // seconds within the day, up to 99:99:99
  localparam int unsigned EpochW  = 32;
  localparam int unsigned ZoneW   = 17;

  localparam logic [DaysW-1:0]  DaysTo2000 = 16'd10957;
  localparam logic [EpochW-1:0] SecPerDay  = 32'd86400;
  localparam logic [ZoneW-1:0]  ZoneReset  = 17'd28800;
  localparam logic [BinW-1:0]   MonthFeb   = 7'd2;
  localparam logic [BinW-1:0]   MonthMax   = 7'd12;
  localparam logic [BinW-1:0]   DayMax     = 7'd31;

  // one time reading after bcd decode
  typedef struct packed {
    logic [BinW-1:0] year;
    logic [BinW-1:0] month;
    logic [BinW-1:0] day;
    logic [BinW-1:0] hour;
    logic [BinW-1:0] minute;
    logic [BinW-1:0] second;
    logic            bad;
  } dec_t;

  // days before the first of the month in a common year (month 1..12)
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[sv/bdu_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdu channel interfaces
// valid/ready channels for time readings in and epoch words out
// ----------------------------------------------------------------------------
interface bdu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] year_bcd;
  logic [7:0] month_bcd;
  logic [7:0] day_bcd;
  logic [7:0] hour_bcd;
  logic [7:0] minute_bcd;
  logic [7:0] second_bcd;

  modport source (output valid, year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd,
                  second_bcd, input ready);
  modport sink   (input valid, year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd,
                  second_bcd, output ready);
endinterface

interface bdu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;
  logic        bad_input;

  modport source (output valid, epoch_seconds, bad_input, input ready);
  modport sink   (input valid, epoch_seconds, bad_input, output ready);
endinterface

[sv/bdu_bcd_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdu_bcd_decode
// turns six bcd fields into binary and flags bad digits, month or day
// ----------------------------------------------------------------------------
module bdu_bcd_decode (
  input  logic [bdu_pkg::FieldW-1:0] year_bcd,
  input  logic [bdu_pkg::FieldW-1:0] month_bcd,
  input  logic [bdu_pkg::FieldW-1:0] day_bcd,
  input  logic [bdu_pkg::FieldW-1:0] hour_bcd,
  input  logic [bdu_pkg::FieldW-1:0] minute_bcd,
  input  logic [bdu_pkg::FieldW-1:0] second_bcd,
  output bdu_pkg::dec_t              dec
);

  function automatic logic [bdu_pkg::BinW-1:0] bcd_bin(input logic [7:0] v);
    return {3'b000, v[7:4]} * 7'd10 + {3'b000, v[3:0]};
  endfunction

  function automatic logic bcd_ok(input logic [7:0] v);
    return (v[7:4] <= 4'd9) && (v[3:0] <= 4'd9);
  endfunction

  logic digits_ok;
  logic range_ok;

  always_comb begin
    dec.year   = bcd_bin(year_bcd);
    dec.month  = bcd_bin(month_bcd);
    dec.day    = bcd_bin(day_bcd);
    dec.hour   = bcd_bin(hour_bcd);
    dec.minute = bcd_bin(minute_bcd);
    dec.second = bcd_bin(second_bcd);
    digits_ok  = bcd_ok(year_bcd) && bcd_ok(month_bcd) && bcd_ok(day_bcd)
                 && bcd_ok(hour_bcd) && bcd_ok(minute_bcd) && bcd_ok(second_bcd);
    range_ok   = (dec.month != '0) && (dec.month <= bdu_pkg::MonthMax)
                 && (dec.day != '0) && (dec.day <= bdu_pkg::DayMax);
    dec.bad    = !(digits_ok && range_ok);
  end

endmodule

[sv/bcd_datetime_to_unix_time.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_datetime_to_unix_time
// converts a bcd clock reading (2000s) to 32-bit seconds since 1970 utc
// ----------------------------------------------------------------------------
// usage
//   in_ch  : valid/ready word with six bcd fields: year, month, day,
//            hour, minute, second
//   out_ch : valid/ready word with epoch_seconds and bad_input; a bad
//            bcd digit, month or day gives bad_input = 1 and zero seconds
//   cfg_*  : cfg_we writes the signed zone offset (seconds subtracted
//            from local time); write only while the pipe is empty
// timing
//   four register stages: decode, day count / time of day, day multiply,
//   final add into the output register
//   throughput one word per clock while out_ch is not stalled; the whole
//   pipe advances together
// reset
//   rst_n (synchronous) empties the pipe and loads eight hours of offset
// stall
//   while out_ch holds a word that is not taken, the pipe freezes and
//   in_ch.ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module bcd_datetime_to_unix_time (
  input  logic                        clk,
  input  logic                        rst_n,
  bdu_in_if.sink                      in_ch,
  bdu_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic signed [bdu_pkg::ZoneW-1:0] cfg_wdata
);

  // pipe advances when the output slot is free or being emptied
  logic advance;

  // zone offset register
  logic [bdu_pkg::ZoneW-1:0] zone_r;

  // stage 1: decoded fields
  logic          s1_vld_r;
  bdu_pkg::dec_t s1_dec_r;
  bdu_pkg::dec_t dec;

  // stage 2: days since epoch and seconds within the day
  logic                      s2_vld_r;
  logic                      s2_bad_r;
  logic [bdu_pkg::DaysW-1:0] s2_days_r;
  logic [bdu_pkg::DaysW-1:0] s2_days_nxt;
  logic [bdu_pkg::HmsW-1:0]  s2_hms_r;
  logic [bdu_pkg::HmsW-1:0]  s2_hms_nxt;

  // stage 3: day seconds product
  logic                       s3_vld_r;
  logic                       s3_bad_r;
  logic [bdu_pkg::EpochW-1:0] s3_prod_r;
  logic [bdu_pkg::HmsW-1:0]   s3_hms_r;

  // stage 4: output register
  logic                       out_vld_r;
  logic                       out_bad_r;
  logic [bdu_pkg::EpochW-1:0] out_epoch_r;
  logic [bdu_pkg::EpochW-1:0] out_epoch_nxt;

  assign advance     = !out_vld_r || out_ch.ready;
  assign in_ch.ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= bdu_pkg::ZoneReset;
    end else if (cfg_we) begin
      zone_r <= cfg_wdata;
    end
  end

  bdu_bcd_decode u_dec (
    .year_bcd   (in_ch.year_bcd),
    .month_bcd  (in_ch.month_bcd),
    .day_bcd    (in_ch.day_bcd),
    .hour_bcd   (in_ch.hour_bcd),
    .minute_bcd (in_ch.minute_bcd),
    .second_bcd (in_ch.second_bcd),
    .dec        (dec)
  );

  // closed-form day count: every fourth year from 2000 is leap in this range
  always_comb begin
    logic [7:0] leaps;
    logic       leap_adj;
    leaps    = ({1'b0, s1_dec_r.year} + 8'd3) >> 2;
    leap_adj = (s1_dec_r.month > bdu_pkg::MonthFeb) && (s1_dec_r.year[1:0] == 2'b00);
    s2_days_nxt = bdu_pkg::DaysTo2000
                + 16'({9'd0, s1_dec_r.year} * 16'd365)
                + {8'd0, leaps}
                + {7'd0, bdu_pkg::month_start(s1_dec_r.month[3:0])}
                + {15'd0, leap_adj}
                + {9'd0, s1_dec_r.day} - 16'd1;
    s2_hms_nxt  = 19'({12'd0, s1_dec_r.hour} * 19'd3600)
                + 19'({12'd0, s1_dec_r.minute} * 19'd60)
                + {12'd0, s1_dec_r.second};
  end

  // local seconds minus the sign-extended zone offset, zero when bad
  always_comb begin
    logic [bdu_pkg::EpochW-1:0] local_sec;
    local_sec     = s3_prod_r + {13'd0, s3_hms_r};
    out_epoch_nxt = s3_bad_r ? '0
                  : local_sec - {{(bdu_pkg::EpochW - bdu_pkg::ZoneW){zone_r[bdu_pkg::ZoneW-1]}},
                                 zone_r};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r  <= in_ch.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  // payload, frozen together with the valid bits on a stall
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_dec_r    <= dec;
      s2_bad_r    <= s1_dec_r.bad;
      s2_days_r   <= s2_days_nxt;
      s2_hms_r    <= s2_hms_nxt;
      s3_bad_r    <= s2_bad_r;
      s3_prod_r   <= 32'({16'd0, s2_days_r} * bdu_pkg::SecPerDay);
      s3_hms_r    <= s2_hms_r;
      out_bad_r   <= s3_bad_r;
      out_epoch_r <= out_epoch_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.bad_input     = out_bad_r;
  assign out_ch.epoch_seconds = out_epoch_r;

endmodule

[sv/bdu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdu_checker
// port-level checks on the converter, bound to the top level
// ----------------------------------------------------------------------------
module bdu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_epoch,
  input logic        out_bad
);

  // a flagged word always carries zero seconds
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad |-> out_epoch == 32'd0)
    else $error("bad word with nonzero seconds");

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_epoch) && $stable(out_bad))
    else $error("output word changed under stall");

  // an empty or draining output slot lets input in
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked with output slot free");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bcd_datetime_to_unix_time bdu_checker u_bdu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_epoch (out_ch.epoch_seconds),
  .out_bad   (out_ch.bad_input)
);
